// ===== rtl/core/max_falling_path_sum_core_assert.svh =====
// Assertion macros for the max falling path sum core.
// Included by files that carry concurrent checks; depends on nothing else.
`ifndef MAX_FALLING_PATH_SUM_CORE_ASSERT_SVH
`define MAX_FALLING_PATH_SUM_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define MFPS_ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("mfps: check failed");
`define MFPS_ASSERT(lbl, prop) `MFPS_ASSERT_CLK(lbl, clk_i, rst_ni, prop)
`else
`define MFPS_ASSERT_CLK(lbl, clk, rst_n, prop)
`define MFPS_ASSERT(lbl, prop)
`endif
`endif

// ===== rtl/core/mfps_pkg.sv =====
// Shared constants and types for the max falling path sum core.
// No dependencies.
package mfps_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int VALUE_BITS_DEF = 16;

  localparam int TILE_W       = 16;  // tile_value field
  localparam int SUM_W        = 26;  // best_total field
  localparam int CFG_W        = 11;
  localparam int CFG_IDX_W    = 2;
  localparam int GRID_DIM_RST = 1024;

  localparam int TILE_DATA_W = 16;
  localparam int OUT_DATA_W  = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_WIDTH  = 2'd0,
    REG_GRID_HEIGHT = 2'd1
  } cfg_reg_e;

  // Which neighbors above take part in the max
  typedef struct packed {
    logic first_row;
    logic use_left;
    logic use_right;
  } nbr_sel_t;

endpackage

// ===== rtl/core/mfps_line_mem.sv =====
// Line store: one write port, one read port, registered read data.
// Depends on nothing; sized by its parameters.
module mfps_line_mem #(
  parameter int DEPTH  = 1024,
  parameter int DATA_W = 26,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] line_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  // read-first: a same-cycle write is not seen by the read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      line_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= line_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/mfps_cfg.sv =====
// Grid dimension registers with range clamping.
// Depends on mfps_pkg.
module mfps_cfg #(
  parameter int MAX_WIDTH  = mfps_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = mfps_pkg::MAX_HEIGHT_DEF,
  parameter int WID_W      = $clog2(MAX_WIDTH + 1),
  parameter int HGT_W      = $clog2(MAX_HEIGHT + 1)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic [mfps_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [mfps_pkg::CFG_W-1:0]     cfg_data_i,
  output logic [WID_W-1:0]               width_o,
  output logic [HGT_W-1:0]               height_o
);
  import mfps_pkg::*;

  localparam int W_RST = (MAX_WIDTH < GRID_DIM_RST) ? MAX_WIDTH : GRID_DIM_RST;
  localparam int H_RST = (MAX_HEIGHT < GRID_DIM_RST) ? MAX_HEIGHT : GRID_DIM_RST;

  logic [WID_W-1:0] width_q, width_d;
  logic [HGT_W-1:0] height_q, height_d;
  logic [31:0]      raw;
  logic [31:0]      w_clamp;
  logic [31:0]      h_clamp;

  // zero acts as one, oversize acts as the maximum
  always_comb begin
    raw = 32'(cfg_data_i);
    if (raw == 32'd0) begin
      w_clamp = 32'd1;
      h_clamp = 32'd1;
    end else begin
      w_clamp = (raw > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) : raw;
      h_clamp = (raw > 32'(MAX_HEIGHT)) ? 32'(MAX_HEIGHT) : raw;
    end
  end

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_GRID_WIDTH:  width_d  = WID_W'(w_clamp);
        REG_GRID_HEIGHT: height_d = HGT_W'(h_clamp);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WID_W'(W_RST);
      height_q <= HGT_W'(H_RST);
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  assign width_o  = width_q;
  assign height_o = height_q;

endmodule

// ===== rtl/core/mfps_best.sv =====
// Tile best: up to three-way max over the row above plus a saturating add; the tile alone on the first row.
// Depends on mfps_pkg.
module mfps_best (
  input  logic [mfps_pkg::SUM_W-1:0] tile_i,
  input  logic [mfps_pkg::SUM_W-1:0] left_i,
  input  logic [mfps_pkg::SUM_W-1:0] mid_i,
  input  logic [mfps_pkg::SUM_W-1:0] right_i,
  input  mfps_pkg::nbr_sel_t         sel_i,
  output logic [mfps_pkg::SUM_W-1:0] best_o
);
  import mfps_pkg::*;

  logic [SUM_W-1:0] m_lm;
  logic [SUM_W-1:0] m_all;
  logic [SUM_W:0]   sum;

  always_comb begin
    m_lm  = (sel_i.use_left && (left_i > mid_i)) ? left_i : mid_i;
    m_all = (sel_i.use_right && (right_i > m_lm)) ? right_i : m_lm;
    sum   = {1'b0, tile_i} + {1'b0, m_all};
    if (sel_i.first_row) begin
      best_o = tile_i;
    end else if (sum[SUM_W]) begin
      best_o = '1;
    end else begin
      best_o = sum[SUM_W-1:0];
    end
  end

endmodule

// ===== rtl/core/max_falling_path_sum_core.sv =====
// Max falling path sum core over a line store; one tile per cycle unless stalled.
// Tiles arrive row-major, top row first, on the slave stream. A tile is taken every
// cycle the input does not stall: on acceptance the line store is read one column ahead
// (or at column 0 on a row's last tile), and in the best stage the tile's best is formed
// from three values of the row above and written back. The line store's single read and
// single write port set that rate. Back-to-back accesses to the same column, which occur
// on grids one or two columns wide, are forwarded around the store. After the last tile
// of the last row the row maximum appears on the master stream once that tile leaves the
// best stage. Input stalls only while a finished result sits unread and the next grid's
// last tile waits behind it. The line store needs no clearing after reset.
// Depends on mfps_pkg, mfps_cfg, mfps_line_mem, mfps_best.
`include "max_falling_path_sum_core_assert.svh"

module max_falling_path_sum_core #(
  parameter int MAX_WIDTH  = mfps_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = mfps_pkg::MAX_HEIGHT_DEF,
  parameter int VALUE_BITS = mfps_pkg::VALUE_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration writes
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [mfps_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [mfps_pkg::CFG_W-1:0]       cfg_data_i,
  // tiles
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [mfps_pkg::TILE_DATA_W-1:0] s_axis_tdata_i,  // [15:0] tile_value
  // results
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  output logic [mfps_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o   // [25:0] best_total
);
  import mfps_pkg::*;

  localparam int VW    = (VALUE_BITS < TILE_W) ? VALUE_BITS : TILE_W;
  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WID_W = $clog2(MAX_WIDTH + 1);
  localparam int HGT_W = $clog2(MAX_HEIGHT + 1);

  logic [WID_W-1:0] width;
  logic [HGT_W-1:0] height;

  // accept side
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic             s_fire;
  logic             row_end_a;
  logic             last_row_a;
  logic [COL_W-1:0] rd_addr;

  // best stage
  logic             s2_valid_q, s2_valid_d;
  logic [VW-1:0]    s2_tile_q;
  logic [COL_W-1:0] s2_col_q;
  logic             s2_first_row_q;
  logic             s2_last_row_q;
  logic             s2_row_end_q;
  logic             s2_self_q;
  logic             s2_grid_end;
  logic             s2_stall;
  logic             s2_fire;
  logic             fwd_q, fwd_d;
  logic [SUM_W-1:0] fwd_data_q;
  logic [SUM_W-1:0] mem_rdata;
  logic [SUM_W-1:0] eff_rd;
  logic [SUM_W-1:0] left_q;
  logic [SUM_W-1:0] mid_q;
  logic [SUM_W-1:0] best;
  logic [SUM_W-1:0] new_max;
  logic [SUM_W-1:0] max_q, max_d;
  nbr_sel_t         sel;

  // result register
  logic             out_valid_q, out_valid_d;
  logic [SUM_W-1:0] out_data_q;
  logic             out_take;

  mfps_cfg #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .WID_W     (WID_W),
    .HGT_W     (HGT_W)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .width_o    (width),
    .height_o   (height)
  );

  assign cfg_ready_o = 1'b1;

  assign s2_grid_end = s2_row_end_q && s2_last_row_q;
  assign s2_stall    = s2_valid_q && s2_grid_end && out_valid_q && !m_axis_tready_i;
  assign s2_fire     = s2_valid_q && !s2_stall;
  assign s_axis_tready_o = !s2_stall;
  assign s_fire      = s_axis_tvalid_i && s_axis_tready_o;
  assign out_take    = out_valid_q && m_axis_tready_i;

  assign row_end_a  = (32'(col_q) + 32'd1) >= 32'(width);
  assign last_row_a = (32'(row_q) + 32'd1) >= 32'(height);
  // a row's last tile fetches column 0 for the next row
  assign rd_addr    = row_end_a ? '0 : COL_W'(32'(col_q) + 32'd1);

  mfps_line_mem #(
    .DEPTH (MAX_WIDTH),
    .DATA_W(SUM_W),
    .ADDR_W(COL_W)
  ) u_line_mem (
    .clk_i  (clk_i),
    .we_i   (s2_fire),
    .waddr_i(s2_col_q),
    .wdata_i(best),
    .re_i   (s_fire),
    .raddr_i(rd_addr),
    .rdata_o(mem_rdata)
  );

  assign eff_rd = fwd_q ? fwd_data_q : mem_rdata;

  always_comb begin
    sel.first_row = s2_first_row_q;
    sel.use_left  = (s2_col_q != '0);
    sel.use_right = !s2_row_end_q;
  end

  mfps_best u_best (
    .tile_i (SUM_W'(s2_tile_q)),
    .left_i (left_q),
    .mid_i  (mid_q),
    .right_i(eff_rd),
    .sel_i  (sel),
    .best_o (best)
  );

  assign new_max = ((s2_col_q == '0) || (best > max_q)) ? best : max_q;

  always_comb begin
    col_d       = col_q;
    row_d       = row_q;
    s2_valid_d  = s2_valid_q;
    fwd_d       = fwd_q;
    max_d       = max_q;
    out_valid_d = out_valid_q;

    if (s_fire) begin
      if (row_end_a && last_row_a) begin
        col_d = '0;
        row_d = '0;
      end else if (row_end_a) begin
        col_d = '0;
        row_d = ROW_W'(32'(row_q) + 32'd1);
      end else begin
        col_d = COL_W'(32'(col_q) + 32'd1);
      end
      // the write landing this edge is missed by the read-first store
      fwd_d = s2_fire && (s2_col_q == rd_addr);
    end

    if (s_fire) begin
      s2_valid_d = 1'b1;
    end else if (s2_fire) begin
      s2_valid_d = 1'b0;
    end

    if (s2_fire && s2_last_row_q) begin
      max_d = s2_grid_end ? '0 : new_max;
    end

    if (s2_fire && s2_grid_end) begin
      out_valid_d = 1'b1;
    end else if (out_take) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      s2_valid_q  <= 1'b0;
      fwd_q       <= 1'b0;
      max_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      col_q       <= col_d;
      row_q       <= row_d;
      s2_valid_q  <= s2_valid_d;
      fwd_q       <= fwd_d;
      max_q       <= max_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      s2_tile_q      <= s_axis_tdata_i[VW-1:0];
      s2_col_q       <= col_q;
      s2_first_row_q <= (row_q == '0);
      s2_last_row_q  <= last_row_a;
      s2_row_end_q   <= row_end_a;
      s2_self_q      <= row_end_a && (col_q == '0);
      fwd_data_q     <= best;
    end
    if (s2_fire) begin
      left_q <= mid_q;
      // one-column grid: the next tile's upper value is this tile's own best
      mid_q  <= s2_self_q ? best : eff_rd;
    end
    if (s2_fire && s2_grid_end) begin
      out_data_q <= new_max;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OUT_DATA_W - SUM_W){1'b0}}, out_data_q};

  `MFPS_ASSERT(a_result_from_grid_end,
    (m_axis_tvalid_o && !$past(m_axis_tvalid_o)) |-> $past(s2_valid_q && s2_grid_end))
  `MFPS_ASSERT(a_stage_holds_tile, (s2_valid_q && !s2_fire) |=> s2_valid_q)
  `MFPS_ASSERT(a_fwd_on_collision,
    (s_fire && s2_fire && (s2_col_q == rd_addr)) |=> fwd_q)

endmodule
